// ----- src/fqs_pkg.sv -----
// Shared types, constants and helpers for the statistics FIFO.
// Depends on nothing; used by fifo_queue_with_statistics.
package fqs_pkg;

	// Queue geometry
	localparam int DEPTH      = 4096;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int PTR_W      = $clog2(2 * DEPTH);
	localparam int PTR_SPAN   = 2 * DEPTH;

	// Fixed field widths of the result
	localparam int OCC_W = 13;
	localparam int CNT_W = 32;

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [PTR_W-1:0]      ptr_t;
	typedef logic [PTR_W:0]        ptr_wide_t;
	typedef logic [OCC_W-1:0]      occ_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// Request codes
	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	// Running statistics
	typedef struct packed {
		cnt_t push_count;
		cnt_t pop_count;
		cnt_t refused_push_count;
		ptr_t peak_depth;
		cnt_t empty_run;
		cnt_t full_run;
	} stats_t;

	// Increment, holding at all ones
	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == '1) ? v : v + cnt_t'(1);
	endfunction

	// Advance a pointer modulo twice the depth
	function automatic ptr_t ptr_next(input ptr_t p);
		return (p == ptr_t'(PTR_SPAN - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	// Slot addressed by a pointer
	function automatic addr_t slot_of(input ptr_t p);
		ptr_t s;
		s = (p >= ptr_t'(DEPTH)) ? p - ptr_t'(DEPTH) : p;
		return addr_t'(s);
	endfunction

	// Words held between head and tail
	function automatic ptr_t fill_level(input ptr_t tail, input ptr_t head);
		ptr_wide_t d;
		if (tail >= head) begin
			d = ptr_wide_t'(tail) - ptr_wide_t'(head);
		end else begin
			d = ptr_wide_t'(tail) + ptr_wide_t'(PTR_SPAN) - ptr_wide_t'(head);
		end
		return ptr_t'(d);
	endfunction

endpackage

// ----- src/fqs_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; hold the word when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/fifo_queue_with_statistics.sv -----
// Ring-buffer FIFO with running statistics, top level.
// Depends on fqs_pkg and fqs_ram.
//
// channel | dir | tdata                    | tuser
// --------+-----+--------------------------+---------------------
// s_*     | in  | write_data               | kind
// m_*     | out | read_data .. full_streak | success
//
// One request is taken every cycle unless s_tready is low; the result is
// registered first in the middle stage (state update and RAM read), then in the
// output register. The slot RAM read port sets the extra stage.
// Reset clears pointers, statistics and valid flags; slot contents stay
// undefined and need no clearing pass. An output stall fills the middle
// stage first, then holds off the input.
module fifo_queue_with_statistics (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [31:0]   s_tdata,   // [31:0] write_data
	input  logic [1:0]    s_tuser,   // [1:0] kind
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [223:0]  m_tdata,   // [31:0] read_data, [44:32] occupancy,
	                                 // [76:45] pushes_total, [108:77] pops_total,
	                                 // [140:109] contention_total,
	                                 // [153:141] high_water, [185:154] empty_streak,
	                                 // [217:186] full_streak, [223:218] zero
	output logic [0:0]    m_tuser    // [0] success
);

	// Queue state
	fqs_pkg::ptr_t   head_q, tail_q;
	fqs_pkg::stats_t stats_q;

	// Next-state decode
	fqs_pkg::kind_t  kind;
	fqs_pkg::ptr_t   fill, occ_nxt, head_nxt, tail_nxt;
	fqs_pkg::stats_t stats_nxt;
	logic            is_full, is_empty;
	logic            push_ok, pop_ok, ok;

	// Middle stage
	logic            valid_s1, success_s1, pop_ok_s1;
	fqs_pkg::ptr_t   occ_s1;
	fqs_pkg::stats_t stats_s1;

	// Output register
	logic            valid_q, success_q;
	logic [31:0]     read_data_q;
	fqs_pkg::ptr_t   occ_q;
	fqs_pkg::stats_t stats_out_q;

	logic            accept, move_s1;
	fqs_pkg::word_t  ram_rdata;

	// Handshake: middle stage drains into the output register
	assign move_s1  = valid_s1 && (!valid_q || m_tready);
	assign s_tready = !valid_s1 || move_s1;
	assign accept   = s_tvalid && s_tready;

	assign kind     = fqs_pkg::kind_t'(s_tuser);
	assign fill     = fqs_pkg::fill_level(tail_q, head_q);
	assign is_full  = (fill >= fqs_pkg::ptr_t'(fqs_pkg::DEPTH));
	assign is_empty = (fill == '0);

	// Decode the request against the current state
	always_comb begin
		stats_nxt = stats_q;
		head_nxt  = head_q;
		tail_nxt  = tail_q;
		push_ok   = 1'b0;
		pop_ok    = 1'b0;
		ok        = 1'b0;
		unique case (kind)
			fqs_pkg::KIND_PUSH: begin
				if (is_full) begin
					stats_nxt.full_run           = fqs_pkg::sat_inc(stats_q.full_run);
					stats_nxt.refused_push_count =
						fqs_pkg::sat_inc(stats_q.refused_push_count);
				end else begin
					push_ok              = 1'b1;
					ok                   = 1'b1;
					stats_nxt.full_run   = '0;
					stats_nxt.push_count = fqs_pkg::sat_inc(stats_q.push_count);
					tail_nxt             = fqs_pkg::ptr_next(tail_q);
					if (fill + fqs_pkg::ptr_t'(1) > stats_q.peak_depth) begin
						stats_nxt.peak_depth = fill + fqs_pkg::ptr_t'(1);
					end
				end
			end
			fqs_pkg::KIND_POP: begin
				if (is_empty) begin
					stats_nxt.empty_run = fqs_pkg::sat_inc(stats_q.empty_run);
				end else begin
					pop_ok              = 1'b1;
					ok                  = 1'b1;
					stats_nxt.empty_run = '0;
					stats_nxt.pop_count = fqs_pkg::sat_inc(stats_q.pop_count);
					head_nxt            = fqs_pkg::ptr_next(head_q);
				end
			end
			fqs_pkg::KIND_CLEAR: begin
				ok        = 1'b1;
				stats_nxt = '0;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	assign occ_nxt = push_ok ? fill + fqs_pkg::ptr_t'(1) :
	                 pop_ok  ? fill - fqs_pkg::ptr_t'(1) : fill;

	// Slot storage: write at tail on push, read at head on pop
	fqs_ram #(
		.WIDTH (fqs_pkg::DATA_WIDTH),
		.DEPTH (fqs_pkg::DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (accept && push_ok),
		.waddr (fqs_pkg::slot_of(tail_q)),
		.wdata (fqs_pkg::word_t'(s_tdata)),
		.re    (accept && pop_ok),
		.raddr (fqs_pkg::slot_of(head_q)),
		.rdata (ram_rdata)
	);

	// Advance queue state on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			stats_q <= '0;
		end else if (accept) begin
			head_q  <= head_nxt;
			tail_q  <= tail_nxt;
			stats_q <= stats_nxt;
		end
	end

	// Middle stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Middle stage payload; the popped word arrives from the RAM alongside
	always_ff @(posedge clk) begin
		if (accept) begin
			success_s1 <= ok;
			pop_ok_s1  <= pop_ok;
			occ_s1     <= occ_nxt;
			stats_s1   <= stats_nxt;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (move_s1) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (move_s1) begin
			success_q   <= success_s1;
			read_data_q <= pop_ok_s1 ? 32'(ram_rdata) : 32'd0;
			occ_q       <= occ_s1;
			stats_out_q <= stats_s1;
		end
	end

	// Pack the result
	assign m_tvalid   = valid_q;
	assign m_tuser[0] = success_q;
	assign m_tdata    = {
		6'd0,
		stats_out_q.full_run,
		stats_out_q.empty_run,
		fqs_pkg::occ_t'(stats_out_q.peak_depth),
		stats_out_q.refused_push_count,
		stats_out_q.pop_count,
		stats_out_q.push_count,
		fqs_pkg::occ_t'(occ_q),
		read_data_q
	};

	// Occupancy never exceeds the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		fill <= fqs_pkg::ptr_t'(fqs_pkg::DEPTH))
		else $error("occupancy beyond depth");

	// A refused push leaves the write pointer alone
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == fqs_pkg::KIND_PUSH && is_full |=> $stable(tail_q))
		else $error("refused push moved tail");

	// A refused pop leaves the read pointer alone
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == fqs_pkg::KIND_POP && is_empty |=> $stable(head_q))
		else $error("refused pop moved head");

	// A successful pop zeroes the empty streak
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && pop_ok |=> stats_q.empty_run == '0)
		else $error("empty streak not zeroed by pop");

endmodule

// ----- tb/sv/fifo_queue_with_statistics_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for fifo_queue_with_statistics: pushes, pops, clears and
// spare codes are streamed in, every result is checked against an in-bench queue model.
// Depends on fqs_pkg and the fifo_queue_with_statistics RTL.
module fifo_queue_with_statistics_test;

	// Request code the block ignores
	localparam logic [1:0] KIND_SPARE = 2'd3;
	// Requests left at the end of the stream below which no new idling is planned
	localparam int CALM_TAIL = 100;
	localparam int SETTLE_CYCLES = 10;

	typedef struct {
		logic [1:0]     kind;
		fqs_pkg::word_t data;
	} request_t;

	typedef struct packed {
		logic           success;
		fqs_pkg::word_t read_data;
		fqs_pkg::occ_t  occupancy;
		fqs_pkg::cnt_t  pushes_total;
		fqs_pkg::cnt_t  pops_total;
		fqs_pkg::cnt_t  contention_total;
		fqs_pkg::occ_t  high_water;
		fqs_pkg::cnt_t  empty_streak;
		fqs_pkg::cnt_t  full_streak;
		logic [5:0]     pad;
	} queue_report_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [31:0]  s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [223:0] m_tdata;
	logic [0:0]   m_tuser;

	fifo_queue_with_statistics dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Stimulus and expected results
	request_t      pending[$];
	queue_report_t due_reports[$];
	int            total_requests;
	int            accepted_count = 0;
	int            fault_count = 0;
	int            cycle_count = 0;
	int            cycle_limit = 0;
	int            gen_fill = 0;

	// Model state: held words and running statistics
	fqs_pkg::word_t held_words[$];
	fqs_pkg::cnt_t  push_total_m, pop_total_m, refused_total_m, empty_run_m, full_run_m;
	fqs_pkg::occ_t  peak_m;

	// Idle control for both sides
	int src_burst = 0, src_quiet = 0, snk_burst = 0, snk_quiet = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic fqs_pkg::cnt_t bump(input fqs_pkg::cnt_t v);
		return (v == '1) ? v : v + 1;
	endfunction

	// Apply one request to the model and build the result it should produce
	function automatic queue_report_t apply_request(input logic [1:0] kind,
			input fqs_pkg::word_t data);
		queue_report_t r;
		r = '0;
		case (kind)
			fqs_pkg::KIND_PUSH: begin
				if (held_words.size() >= fqs_pkg::DEPTH) begin
					full_run_m = bump(full_run_m);
					refused_total_m = bump(refused_total_m);
				end else begin
					full_run_m = '0;
					held_words.push_back(data);
					push_total_m = bump(push_total_m);
					if (fqs_pkg::occ_t'(held_words.size()) > peak_m)
						peak_m = fqs_pkg::occ_t'(held_words.size());
					r.success = 1'b1;
				end
			end
			fqs_pkg::KIND_POP: begin
				if (held_words.size() == 0) begin
					empty_run_m = bump(empty_run_m);
				end else begin
					empty_run_m = '0;
					r.read_data = held_words.pop_front();
					pop_total_m = bump(pop_total_m);
					r.success = 1'b1;
				end
			end
			fqs_pkg::KIND_CLEAR: begin
				push_total_m = '0;
				pop_total_m = '0;
				refused_total_m = '0;
				peak_m = '0;
				empty_run_m = '0;
				full_run_m = '0;
				r.success = 1'b1;
			end
			default: ;
		endcase
		r.occupancy = fqs_pkg::occ_t'(held_words.size());
		r.pushes_total = push_total_m;
		r.pops_total = pop_total_m;
		r.contention_total = refused_total_m;
		r.high_water = peak_m;
		r.empty_streak = empty_run_m;
		r.full_streak = full_run_m;
		return r;
	endfunction

	// Append a request and track the fill level it leads to
	task automatic queue_request(input logic [1:0] kind, input fqs_pkg::word_t data);
		request_t q;
		q.kind = kind;
		q.data = data;
		pending.push_back(q);
		if (kind == fqs_pkg::KIND_PUSH && gen_fill < fqs_pkg::DEPTH)
			gen_fill++;
		else if (kind == fqs_pkg::KIND_POP && gen_fill > 0)
			gen_fill--;
	endtask

	// Random stretches, each leaning toward pushes, pops or neither
	task automatic random_stretch(input int n);
		int counted;
		int seg;
		int push_pct;
		int r;
		counted = 0;
		while (counted < n) begin
			seg = $urandom_range(30, 80);
			case ($urandom_range(0, 2))
				0: push_pct = 20;
				1: push_pct = 50;
				default: push_pct = 80;
			endcase
			repeat (seg) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					queue_request(KIND_SPARE, $urandom());
				end else begin
					if (r < 8)
						queue_request(fqs_pkg::KIND_CLEAR, $urandom());
					else if ($urandom_range(0, 99) < push_pct)
						queue_request(fqs_pkg::KIND_PUSH, $urandom());
					else
						queue_request(fqs_pkg::KIND_POP, $urandom());
					counted++;
				end
			end
		end
	endtask

	// Start an idle burst or a quiet stretch now and then
	task automatic plan_idle(inout int burst, inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
		end else begin
			r = $urandom_range(0, 15);
			if (r < 2)
				burst = $urandom_range(1, 13);
			else if (r == 2)
				quiet = $urandom_range(20, 80);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fault_count++;
			$display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Build the stimulus, run it, then wait for the last result
	initial begin
		push_total_m = '0;
		pop_total_m = '0;
		refused_total_m = '0;
		empty_run_m = '0;
		full_run_m = '0;
		peak_m = '0;

		// Directed: empty pops, spare code, data extremes, clear with data held
		queue_request(fqs_pkg::KIND_POP, 32'h0);
		queue_request(fqs_pkg::KIND_POP, 32'hFFFF_FFFF);
		queue_request(KIND_SPARE, 32'hFFFF_FFFF);
		queue_request(fqs_pkg::KIND_PUSH, 32'h0000_0000);
		queue_request(fqs_pkg::KIND_PUSH, 32'hFFFF_FFFF);
		queue_request(fqs_pkg::KIND_PUSH, 32'hA5A5_A5A5);
		queue_request(fqs_pkg::KIND_PUSH, 32'h5A5A_5A5A);
		queue_request(fqs_pkg::KIND_POP, 32'h0);
		queue_request(fqs_pkg::KIND_POP, 32'h0);
		queue_request(fqs_pkg::KIND_CLEAR, 32'hFFFF_FFFF);
		queue_request(fqs_pkg::KIND_PUSH, 32'h1234_5678);
		queue_request(KIND_SPARE, 32'h0);
		queue_request(fqs_pkg::KIND_POP, 32'h0);
		queue_request(fqs_pkg::KIND_POP, 32'h0);
		queue_request(fqs_pkg::KIND_POP, 32'h0);
		queue_request(fqs_pkg::KIND_POP, 32'h0);
		queue_request(fqs_pkg::KIND_POP, 32'h0);
		queue_request(fqs_pkg::KIND_CLEAR, 32'h0);
		queue_request(fqs_pkg::KIND_PUSH, $urandom());
		queue_request(fqs_pkg::KIND_CLEAR, 32'h0);
		queue_request(fqs_pkg::KIND_POP, 32'h0);

		random_stretch(450);

		// Fill to the brim, push against a full queue, then drain it dry
		while (gen_fill < fqs_pkg::DEPTH)
			queue_request(fqs_pkg::KIND_PUSH, $urandom());
		repeat (3) queue_request(fqs_pkg::KIND_PUSH, $urandom());
		queue_request(fqs_pkg::KIND_POP, 32'h0);
		queue_request(fqs_pkg::KIND_PUSH, $urandom());
		queue_request(fqs_pkg::KIND_PUSH, $urandom());
		queue_request(fqs_pkg::KIND_CLEAR, 32'h0);
		queue_request(fqs_pkg::KIND_PUSH, $urandom());
		queue_request(KIND_SPARE, $urandom());
		while (gen_fill > 0)
			queue_request(fqs_pkg::KIND_POP, 32'h0);
		repeat (2) queue_request(fqs_pkg::KIND_POP, 32'h0);

		random_stretch(450);

		total_requests = pending.size();
		cycle_limit = total_requests * 60 + 5000;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count != total_requests)
			@(posedge clk);
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("[fifo_queue_with_statistics] OK");
		else
			$display("[fifo_queue_with_statistics] ERROR");
		$finish;
	end

	// Driver: predict each accepted transfer, then present the next request
	always @(posedge clk) begin
		request_t q;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				due_reports.push_back(apply_request(s_tuser, s_tdata));
				accepted_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_burst > 0) begin
					src_burst--;
					s_tvalid <= 1'b0;
				end else if (pending.size() > 0) begin
					q = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= q.data;
					s_tuser <= q.kind;
					if (pending.size() > CALM_TAIL)
						plan_idle(src_burst, src_quiet);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer against the oldest expectation
	always @(posedge clk) begin
		queue_report_t want;
		queue_report_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tuser[0], m_tdata[31:0], m_tdata[44:32], m_tdata[76:45],
					m_tdata[108:77], m_tdata[140:109], m_tdata[153:141],
					m_tdata[185:154], m_tdata[217:186], m_tdata[223:218]};
				if (due_reports.size() == 0) begin
					fault_count++;
					$display("%0t unexpected result: expected none, actual %0h", $time, got);
				end else begin
					want = due_reports.pop_front();
					check_field("success", 32'(want.success), 32'(got.success));
					check_field("read_data", want.read_data, got.read_data);
					check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
					check_field("pushes_total", want.pushes_total, got.pushes_total);
					check_field("pops_total", want.pops_total, got.pops_total);
					check_field("contention_total", want.contention_total,
						got.contention_total);
					check_field("high_water", 32'(want.high_water), 32'(got.high_water));
					check_field("empty_streak", want.empty_streak, got.empty_streak);
					check_field("full_streak", want.full_streak, got.full_streak);
					check_field("tdata pad", 32'(want.pad), 32'(got.pad));
				end
			end
			// Stall the result side in bursts, none planned near the end
			if (snk_burst > 0) begin
				snk_burst--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (pending.size() > CALM_TAIL)
					plan_idle(snk_burst, snk_quiet);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_limit != 0 && cycle_count == cycle_limit) begin
			$display("[fifo_queue_with_statistics] ERROR");
			$finish;
		end
	end

endmodule

// ----- fifo_queue_with_statistics.f -----
src/fqs_pkg.sv
src/fqs_ram.sv
src/fifo_queue_with_statistics.sv
tb/sv/fifo_queue_with_statistics_test.sv
